// ===== design/script_token_lexer_defines.svh =====
// assertion macros for the script token lexer
`ifndef SCRIPT_TOKEN_LEXER_DEFINES_SVH
`define SCRIPT_TOKEN_LEXER_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked outside reset
`define STL_ASSERT_IMP(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define STL_ASSERT_NXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`else

`define STL_ASSERT_IMP(lbl, cond, conseq, msg)
`define STL_ASSERT_NXT(lbl, cond, conseq, msg)

`endif

`endif

// ===== design/stl_pkg.sv =====
`timescale 1ns / 1ps

package stl_pkg;

  // one input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_source;
  } stl_in_t;

  // one result item
  typedef struct packed {
    logic       text_valid;
    logic [7:0] text_byte;
    logic       token_valid;
    logic [4:0] token_kind;
    logic [1:0] error_code;
    logic       last_of_run;
  } stl_out_t;

  // lexer mode between bytes
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_STRING,
    MODE_CHAR,
    MODE_EQ,
    MODE_BANG
  } lex_mode_t;

  // token kind codes
  typedef enum logic [4:0] {
    KIND_NUMBER   = 5'd0,
    KIND_LITERAL  = 5'd1,
    KIND_KW_SMILE = 5'd2,
    KIND_KW_INT   = 5'd3,
    KIND_KW_FLOAT = 5'd4,
    KIND_KW_STR   = 5'd5,
    KIND_KW_ANA   = 5'd6,
    KIND_KW_ELSA  = 5'd7,
    KIND_IDENT    = 5'd8,
    KIND_PLUS     = 5'd9,
    KIND_MINUS    = 5'd10,
    KIND_STAR     = 5'd11,
    KIND_SLASH    = 5'd12,
    KIND_LPAREN   = 5'd13,
    KIND_RPAREN   = 5'd14,
    KIND_SEMI     = 5'd15,
    KIND_DEQ      = 5'd16,
    KIND_EQ       = 5'd17,
    KIND_NEQ      = 5'd18,
    KIND_END      = 5'd19
  } token_kind_t;

  // error codes
  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_STRING = 2'd1,
    ERR_CHAR   = 2'd2
  } err_code_t;

  // lexer state carried from item to item
  typedef struct packed {
    lex_mode_t  mode;
    logic [5:0] kw_cand;
    logic [2:0] ident_len;
    logic [1:0] lit_seen;
    logic       err_latched;
  } stl_state_t;

  // result queue depth
  localparam int RES_FIFO_DEPTH = 4;

endpackage

// ===== design/stl_step.sv =====
`timescale 1ns / 1ps

module stl_step (
  input  stl_pkg::stl_in_t    item,
  input  stl_pkg::stl_state_t state,
  output stl_pkg::stl_state_t state_nxt,
  output stl_pkg::stl_out_t   res0,
  output stl_pkg::stl_out_t   res1,
  output logic [1:0]          res_cnt
);
  import stl_pkg::*;

  localparam int NUM_KW = 6;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  // keyword text, padded with zero to eight places
  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{"s", "m", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
    '{"s", "t", "r", "i", "n", "g", 8'h00, 8'h00},
    '{"a", "n", "a", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "a", 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd5, 3'd3, 3'd5, 3'd6, 3'd3, 3'd4};

  // decode of a byte that arrives between tokens
  typedef struct packed {
    lex_mode_t  mode;
    logic       has_res;
    stl_out_t   res;
    logic       set_ident;
    logic [5:0] kw_cand;
    logic       clr_lit;
  } start_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic stl_out_t mk_res(input logic tv, input logic [7:0] tb, input logic kv,
                                      input logic [4:0] kind, input logic [1:0] err);
    stl_out_t r;
    r.text_valid  = tv;
    r.text_byte   = tv ? tb : 8'h00;
    r.token_valid = kv;
    r.token_kind  = kv ? kind : 5'd0;
    r.error_code  = err;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic stl_out_t mk_tok(input logic [4:0] kind);
    return mk_res(1'b0, 8'h00, 1'b1, kind, ERR_NONE);
  endfunction

  function automatic stl_out_t mk_text(input logic [7:0] b);
    return mk_res(1'b1, b, 1'b0, KIND_NUMBER, ERR_NONE);
  endfunction

  function automatic stl_out_t mk_err(input logic [1:0] err);
    return mk_res(1'b0, 8'h00, 1'b0, KIND_NUMBER, err);
  endfunction

  // narrow the keyword candidates by one more identifier byte
  function automatic logic [5:0] kw_push(input logic [5:0] cand, input logic [2:0] len,
                                         input logic [7:0] b);
    logic [5:0] keep;
    for (int k = 0; k < NUM_KW; k++) begin
      keep[k] = cand[k] && (len < KW_LEN[k]) && (KW_TEXT[k][len] == b);
    end
    return keep;
  endfunction

  // kind of a finished identifier, lowest keyword wins
  function automatic logic [4:0] ident_kind(input logic [5:0] cand, input logic [2:0] len);
    logic [4:0] kind;
    kind = KIND_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (cand[k] && (KW_LEN[k] == len)) begin
        kind = 5'(KIND_KW_SMILE) + 5'(k);
      end
    end
    return kind;
  endfunction

  function automatic start_t start_token(input logic [7:0] b);
    start_t s;
    s.mode      = MODE_IDLE;
    s.has_res   = 1'b0;
    s.res       = '0;
    s.set_ident = 1'b0;
    s.kw_cand   = kw_push(6'h3F, 3'd0, b);
    s.clr_lit   = 1'b0;
    if (is_digit(b)) begin
      s.mode    = MODE_NUMBER;
      s.has_res = 1'b1;
      s.res     = mk_text(b);
    end else if (is_alpha(b)) begin
      s.mode      = MODE_IDENT;
      s.has_res   = 1'b1;
      s.res       = mk_text(b);
      s.set_ident = 1'b1;
    end else if (b == CH_DQUOTE) begin
      s.mode = MODE_STRING;
    end else if (b == CH_SQUOTE) begin
      s.mode    = MODE_CHAR;
      s.clr_lit = 1'b1;
    end else if (b == CH_EQUAL) begin
      s.mode = MODE_EQ;
    end else if (b == CH_BANG) begin
      s.mode = MODE_BANG;
    end else begin
      s.has_res = 1'b1;
      case (b)
        "+":     s.res = mk_tok(KIND_PLUS);
        "-":     s.res = mk_tok(KIND_MINUS);
        "*":     s.res = mk_tok(KIND_STAR);
        "/":     s.res = mk_tok(KIND_SLASH);
        "(":     s.res = mk_tok(KIND_LPAREN);
        ")":     s.res = mk_tok(KIND_RPAREN);
        ";":     s.res = mk_tok(KIND_SEMI);
        default: s.has_res = 1'b0;
      endcase
    end
    return s;
  endfunction

  logic [7:0] b;
  start_t     st;
  logic       alnum;
  logic [2:0] len_inc;
  stl_out_t   r0;
  stl_out_t   r1;
  logic [1:0] cnt;

  assign b       = item.data_byte;
  assign st      = start_token(b);
  assign alnum   = is_alpha(b) || is_digit(b);
  assign len_inc = (state.ident_len == 3'd7) ? 3'd7 : state.ident_len + 3'd1;

  // next state
  always_comb begin
    state_nxt = state;
    if (state.err_latched) begin
      if (item.end_of_source) begin
        state_nxt = '0;
      end
    end else if (item.end_of_source) begin
      if ((state.mode == MODE_STRING) || (state.mode == MODE_CHAR)) begin
        state_nxt.err_latched = 1'b1;
        state_nxt.mode        = MODE_IDLE;
        state_nxt.lit_seen    = 2'd0;
      end else begin
        state_nxt = '0;
      end
    end else begin
      case (state.mode)
        MODE_NUMBER: begin
          if (!(is_digit(b) || (b == CH_DOT))) begin
            state_nxt.mode = st.mode;
          end
        end
        MODE_IDENT: begin
          if (alnum) begin
            state_nxt.kw_cand   = kw_push(state.kw_cand, state.ident_len, b);
            state_nxt.ident_len = len_inc;
          end else begin
            state_nxt.kw_cand   = '0;
            state_nxt.ident_len = 3'd0;
            state_nxt.mode      = st.mode;
          end
        end
        MODE_STRING: begin
          if (b == CH_DQUOTE) begin
            state_nxt.mode = MODE_IDLE;
          end
        end
        MODE_CHAR: begin
          if ((state.lit_seen == 2'd0) && (b == CH_BSLASH)) begin
            state_nxt.lit_seen = 2'd1;
          end else if (state.lit_seen < 2'd2) begin
            state_nxt.lit_seen = 2'd2;
          end else if (b == CH_SQUOTE) begin
            state_nxt.mode     = MODE_IDLE;
            state_nxt.lit_seen = 2'd0;
          end else begin
            state_nxt.err_latched = 1'b1;
            state_nxt.mode        = MODE_IDLE;
            state_nxt.lit_seen    = 2'd0;
          end
        end
        MODE_EQ, MODE_BANG: begin
          state_nxt.mode = (b == CH_EQUAL) ? MODE_IDLE : st.mode;
        end
        default: begin
          state_nxt.mode = st.mode;
        end
      endcase
      // a new token started by this byte
      if ((state.mode == MODE_IDLE) || (((state.mode == MODE_NUMBER)) && !is_digit(b) &&
          (b != CH_DOT)) || ((state.mode == MODE_IDENT) && !alnum) ||
          (((state.mode == MODE_EQ) || (state.mode == MODE_BANG)) && (b != CH_EQUAL))) begin
        if (st.set_ident) begin
          state_nxt.kw_cand   = st.kw_cand;
          state_nxt.ident_len = 3'd1;
        end
        if (st.clr_lit) begin
          state_nxt.lit_seen = 2'd0;
        end
      end
    end
  end

  // results
  always_comb begin
    r0  = '0;
    r1  = '0;
    cnt = 2'd0;
    if (state.err_latched) begin
      cnt = 2'd0;
    end else if (item.end_of_source) begin
      case (state.mode)
        MODE_NUMBER: begin
          r0  = mk_tok(KIND_NUMBER);
          r1  = mk_tok(KIND_END);
          cnt = 2'd2;
        end
        MODE_IDENT: begin
          r0  = mk_tok(ident_kind(state.kw_cand, state.ident_len));
          r1  = mk_tok(KIND_END);
          cnt = 2'd2;
        end
        MODE_EQ: begin
          r0  = mk_tok(KIND_EQ);
          r1  = mk_tok(KIND_END);
          cnt = 2'd2;
        end
        MODE_STRING: begin
          r0  = mk_err(ERR_STRING);
          cnt = 2'd1;
        end
        MODE_CHAR: begin
          r0  = mk_err(ERR_CHAR);
          cnt = 2'd1;
        end
        default: begin
          r0  = mk_tok(KIND_END);
          cnt = 2'd1;
        end
      endcase
    end else begin
      case (state.mode)
        MODE_NUMBER: begin
          if (is_digit(b) || (b == CH_DOT)) begin
            r0  = mk_text(b);
            cnt = 2'd1;
          end else begin
            r0  = mk_tok(KIND_NUMBER);
            r1  = st.res;
            cnt = {1'b0, 1'b1} + {1'b0, st.has_res};
          end
        end
        MODE_IDENT: begin
          if (alnum) begin
            r0  = mk_text(b);
            cnt = 2'd1;
          end else begin
            r0  = mk_tok(ident_kind(state.kw_cand, state.ident_len));
            r1  = st.res;
            cnt = {1'b0, 1'b1} + {1'b0, st.has_res};
          end
        end
        MODE_STRING: begin
          r0  = (b == CH_DQUOTE) ? mk_tok(KIND_LITERAL) : mk_text(b);
          cnt = 2'd1;
        end
        MODE_CHAR: begin
          if ((state.lit_seen == 2'd0) && (b == CH_BSLASH)) begin
            cnt = 2'd0;
          end else if (state.lit_seen < 2'd2) begin
            r0  = mk_text(b);
            cnt = 2'd1;
          end else if (b == CH_SQUOTE) begin
            r0  = mk_tok(KIND_LITERAL);
            cnt = 2'd1;
          end else begin
            r0  = mk_err(ERR_CHAR);
            cnt = 2'd1;
          end
        end
        MODE_EQ: begin
          if (b == CH_EQUAL) begin
            r0  = mk_tok(KIND_DEQ);
            cnt = 2'd1;
          end else begin
            r0  = mk_tok(KIND_EQ);
            r1  = st.res;
            cnt = {1'b0, 1'b1} + {1'b0, st.has_res};
          end
        end
        MODE_BANG: begin
          if (b == CH_EQUAL) begin
            r0  = mk_tok(KIND_NEQ);
            cnt = 2'd1;
          end else begin
            r0  = st.res;
            cnt = {1'b0, st.has_res};
          end
        end
        default: begin
          r0  = st.res;
          cnt = {1'b0, st.has_res};
        end
      endcase
    end
    // mark the final result of this item
    r0.last_of_run = (cnt == 2'd1);
    r1.last_of_run = (cnt == 2'd2);
  end

  assign res0    = r0;
  assign res1    = r1;
  assign res_cnt = cnt;

endmodule

// ===== design/stl_res_fifo.sv =====
`timescale 1ns / 1ps

module stl_res_fifo #(
  parameter int Depth = stl_pkg::RES_FIFO_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [1:0]                 push_cnt,
  input  stl_pkg::stl_out_t          wdata0,
  input  stl_pkg::stl_out_t          wdata1,
  output logic [$clog2(Depth+1)-1:0] free_cnt,
  output logic                       out_valid,
  input  logic                       out_ready,
  output stl_pkg::stl_out_t          out_item
);
  import stl_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  stl_out_t        mem [Depth];
  logic [PtrW-1:0] head_r, head_nxt;
  logic [PtrW-1:0] tail_r, tail_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [PtrW-1:0] tail_p1;
  logic            pop;

  assign pop       = out_valid && out_ready;
  assign tail_p1   = ptr_inc(tail_r);
  assign out_valid = (cnt_r != '0);
  assign out_item  = mem[head_r];
  assign free_cnt  = CntW'(Depth) - cnt_r;

  // pointer and fill bookkeeping
  always_comb begin
    head_nxt = pop ? ptr_inc(head_r) : head_r;
    case (push_cnt)
      2'd1:    tail_nxt = tail_p1;
      2'd2:    tail_nxt = ptr_inc(tail_p1);
      default: tail_nxt = tail_r;
    endcase
    cnt_nxt = cnt_r + CntW'(push_cnt) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // result storage, up to two entries written per cycle
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[tail_r] <= wdata0;
    end
    if (push_cnt == 2'd2) begin
      mem[tail_p1] <= wdata1;
    end
  end

endmodule

// ===== design/script_token_lexer.sv =====
`timescale 1ns / 1ps
// an accepted item waits in the input stage until the result queue has room for its results
// throughput: one item per cycle while the result queue has room and items give at most one
//   result each; the output port drains one result per cycle, limiting items with two results
// reset: synchronous active-low rst_n clears the lexer state, the input stage and the
//   result queue; the lexer starts idle between tokens
`include "script_token_lexer_defines.svh"

module script_token_lexer #(
  parameter int FifoDepth = stl_pkg::RES_FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  stl_pkg::stl_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output stl_pkg::stl_out_t out_item
);
  import stl_pkg::*;

  localparam int CntW = $clog2(FifoDepth + 1);

  logic                in_valid_r, in_valid_nxt;
  stl_in_t             in_item_r;
  stl_state_t          state_r;
  stl_state_t          state_nxt;
  stl_out_t            res0;
  stl_out_t            res1;
  logic [1:0]          res_cnt;
  logic [1:0]          push_cnt;
  logic [CntW-1:0]     free_cnt;
  logic                consume;
  logic                latched_busy;
  logic                eos_done;
  logic                out_err;
  logic                err_closes;
  logic                out_empty;

  // the held item is processed once the queue has room for its results
  assign consume      = in_valid_r && (CntW'(res_cnt) <= free_cnt);
  assign in_ready     = !in_valid_r || consume;
  assign push_cnt     = consume ? res_cnt : 2'd0;
  assign in_valid_nxt = (in_valid && in_ready) || (in_valid_r && !consume);

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
  end

  // lexer state advances with each processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (consume) begin
      state_r <= state_nxt;
    end
  end

  stl_step u_step (
    .item      (in_item_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .res0      (res0),
    .res1      (res1),
    .res_cnt   (res_cnt)
  );

  stl_res_fifo #(
    .Depth (FifoDepth)
  ) u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .wdata0    (res0),
    .wdata1    (res1),
    .free_cnt  (free_cnt),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // check terms
  assign latched_busy = in_valid_r && state_r.err_latched;
  assign eos_done     = consume && in_item_r.end_of_source;
  assign out_err      = out_valid && (out_item.error_code != ERR_NONE);
  assign err_closes   = out_item.last_of_run && !out_item.token_valid;
  assign out_empty    = out_valid && !out_item.text_valid && !out_item.token_valid;

  // checks
  `STL_ASSERT_IMP(a_latched_silent, latched_busy, res_cnt == 2'd0, "latched error gave results")
  `STL_ASSERT_NXT(a_eos_idle, eos_done, state_r.mode == MODE_IDLE, "not idle after end of source")
  `STL_ASSERT_IMP(a_err_last, out_err, err_closes, "error result not final")
  `STL_ASSERT_IMP(a_res_payload, out_empty, out_item.error_code != ERR_NONE, "empty result")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import stl_pkg::*;

  localparam int CLK_HALF   = 10;
  localparam int RESET_CYC  = 4;
  localparam int LIMIT_CYC  = 600000;
  localparam int LONG_HOLD  = 300;
  localparam int DRAIN_CYC  = 8;
  localparam int MAX_REPORT = 10;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  stl_in_t  in_item;
  logic     out_valid;
  logic     out_ready;
  stl_out_t out_item;

  // lexer golden model plus the queue of results still owed by the block
  class lexer_scoreboard;
    lex_mode_t  mode;
    logic [5:0] kw_cand;
    logic [2:0] ident_len;
    logic [1:0] lit_seen;
    logic       err_latched;
    stl_out_t   pending_tokens[$];
    stl_out_t   step_results[$];
    int         mismatches;
    int         results_checked;
    int         tokens_seen;
    int         errors_seen;
    int         bytes_noted;

    function new();
      clear_state();
      mismatches      = 0;
      results_checked = 0;
      tokens_seen     = 0;
      errors_seen     = 0;
      bytes_noted     = 0;
    endfunction

    static function string kw_word(int k);
      case (k)
        0: return "smile";
        1: return "int";
        2: return "float";
        3: return "string";
        4: return "ana";
        default: return "elsa";
      endcase
    endfunction

    static function bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    static function bit is_alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function void clear_state();
      mode        = MODE_IDLE;
      kw_cand     = '0;
      ident_len   = '0;
      lit_seen    = '0;
      err_latched = 1'b0;
    endfunction

    function void emit(logic tv, logic [7:0] tb, logic kv, token_kind_t kind, err_code_t err);
      stl_out_t r;
      r.text_valid  = tv;
      r.text_byte   = tv ? tb : 8'h00;
      r.token_valid = kv;
      r.token_kind  = kv ? kind : KIND_NUMBER;
      r.error_code  = err;
      r.last_of_run = 1'b0;
      step_results.insert(step_results.size(), r);
    endfunction

    // narrow the keyword candidates by the next identifier byte
    function void ident_push(logic [7:0] b);
      logic [5:0] keep;
      string      w;
      keep = '0;
      for (int k = 0; k < 6; k++) begin
        w = kw_word(k);
        if (kw_cand[k] && int'(ident_len) < w.len() && w[ident_len] == b) keep[k] = 1'b1;
      end
      kw_cand = keep;
      if (ident_len < 3'd7) ident_len = ident_len + 3'd1;
    endfunction

    function token_kind_t ident_kind();
      string w;
      for (int k = 0; k < 6; k++) begin
        w = kw_word(k);
        if (kw_cand[k] && w.len() == int'(ident_len))
          return token_kind_t'(int'(KIND_KW_SMILE) + k);
      end
      return KIND_IDENT;
    endfunction

    // byte seen between tokens
    function void start_token(logic [7:0] b);
      if (is_digit(b)) begin
        mode = MODE_NUMBER;
        emit(1'b1, b, 1'b0, KIND_NUMBER, ERR_NONE);
      end else if (is_alpha(b)) begin
        mode      = MODE_IDENT;
        kw_cand   = 6'h3F;
        ident_len = '0;
        ident_push(b);
        emit(1'b1, b, 1'b0, KIND_NUMBER, ERR_NONE);
      end else if (b == "\"") begin
        mode = MODE_STRING;
      end else if (b == "'") begin
        mode     = MODE_CHAR;
        lit_seen = '0;
      end else if (b == "=") begin
        mode = MODE_EQ;
      end else if (b == "!") begin
        mode = MODE_BANG;
      end else begin
        case (b)
          "+": emit(1'b0, 8'h00, 1'b1, KIND_PLUS, ERR_NONE);
          "-": emit(1'b0, 8'h00, 1'b1, KIND_MINUS, ERR_NONE);
          "*": emit(1'b0, 8'h00, 1'b1, KIND_STAR, ERR_NONE);
          "/": emit(1'b0, 8'h00, 1'b1, KIND_SLASH, ERR_NONE);
          "(": emit(1'b0, 8'h00, 1'b1, KIND_LPAREN, ERR_NONE);
          ")": emit(1'b0, 8'h00, 1'b1, KIND_RPAREN, ERR_NONE);
          ";": emit(1'b0, 8'h00, 1'b1, KIND_SEMI, ERR_NONE);
          default: ;
        endcase
      end
    endfunction

    function void latch_error(err_code_t err);
      emit(1'b0, 8'h00, 1'b0, KIND_NUMBER, err);
      err_latched = 1'b1;
      mode        = MODE_IDLE;
      lit_seen    = '0;
    endfunction

    // accepted input item: work out the results it owes
    function void note_input(stl_in_t it);
      logic [7:0] b;
      b = it.data_byte;
      step_results.delete();
      bytes_noted++;
      if (err_latched) begin
        // everything up to the next end of source is swallowed
        if (it.end_of_source) clear_state();
        return;
      end
      if (it.end_of_source) begin
        case (mode)
          MODE_NUMBER: emit(1'b0, 8'h00, 1'b1, KIND_NUMBER, ERR_NONE);
          MODE_IDENT:  emit(1'b0, 8'h00, 1'b1, ident_kind(), ERR_NONE);
          MODE_EQ:     emit(1'b0, 8'h00, 1'b1, KIND_EQ, ERR_NONE);
          MODE_STRING: latch_error(ERR_STRING);
          MODE_CHAR:   latch_error(ERR_CHAR);
          default: ;
        endcase
        if (!err_latched) begin
          emit(1'b0, 8'h00, 1'b1, KIND_END, ERR_NONE);
          clear_state();
        end
      end else begin
        case (mode)
          MODE_NUMBER: begin
            if (is_digit(b) || b == ".") begin
              emit(1'b1, b, 1'b0, KIND_NUMBER, ERR_NONE);
            end else begin
              emit(1'b0, 8'h00, 1'b1, KIND_NUMBER, ERR_NONE);
              mode = MODE_IDLE;
              start_token(b);
            end
          end
          MODE_IDENT: begin
            if (is_alpha(b) || is_digit(b)) begin
              ident_push(b);
              emit(1'b1, b, 1'b0, KIND_NUMBER, ERR_NONE);
            end else begin
              emit(1'b0, 8'h00, 1'b1, ident_kind(), ERR_NONE);
              mode      = MODE_IDLE;
              kw_cand   = '0;
              ident_len = '0;
              start_token(b);
            end
          end
          MODE_STRING: begin
            if (b == "\"") begin
              emit(1'b0, 8'h00, 1'b1, KIND_LITERAL, ERR_NONE);
              mode = MODE_IDLE;
            end else begin
              emit(1'b1, b, 1'b0, KIND_NUMBER, ERR_NONE);
            end
          end
          MODE_CHAR: begin
            // backslash as first character escapes the next byte
            if (lit_seen == 2'd0 && b == "\\") begin
              lit_seen = 2'd1;
            end else if (lit_seen < 2'd2) begin
              emit(1'b1, b, 1'b0, KIND_NUMBER, ERR_NONE);
              lit_seen = 2'd2;
            end else if (b == "'") begin
              emit(1'b0, 8'h00, 1'b1, KIND_LITERAL, ERR_NONE);
              mode     = MODE_IDLE;
              lit_seen = '0;
            end else begin
              latch_error(ERR_CHAR);
            end
          end
          MODE_EQ: begin
            mode = MODE_IDLE;
            if (b == "=") begin
              emit(1'b0, 8'h00, 1'b1, KIND_DEQ, ERR_NONE);
            end else begin
              emit(1'b0, 8'h00, 1'b1, KIND_EQ, ERR_NONE);
              start_token(b);
            end
          end
          MODE_BANG: begin
            mode = MODE_IDLE;
            if (b == "=") emit(1'b0, 8'h00, 1'b1, KIND_NEQ, ERR_NONE);
            else start_token(b);
          end
          default: begin
            mode = MODE_IDLE;
            start_token(b);
          end
        endcase
      end
      if (step_results.size() > 0) begin
        step_results[step_results.size() - 1].last_of_run = 1'b1;
        foreach (step_results[i]) pending_tokens.insert(pending_tokens.size(), step_results[i]);
      end
    endfunction

    function void report(string what, stl_out_t exp, stl_out_t got);
      mismatches++;
      if (mismatches <= MAX_REPORT) begin
        $display("%0t mismatch (%s): exp tv=%0d tb=%02h kv=%0d kind=%0d err=%0d last=%0d",
                 $time, what, exp.text_valid, exp.text_byte, exp.token_valid, exp.token_kind,
                 exp.error_code, exp.last_of_run);
        $display("    got tv=%0d tb=%02h kv=%0d kind=%0d err=%0d last=%0d",
                 got.text_valid, got.text_byte, got.token_valid, got.token_kind,
                 got.error_code, got.last_of_run);
      end
    endfunction

    // accepted result item against the oldest expectation
    function void check_result(stl_out_t got);
      stl_out_t exp;
      results_checked++;
      if (got.token_valid === 1'b1) tokens_seen++;
      if (got.error_code !== ERR_NONE) errors_seen++;
      if (pending_tokens.size() == 0) begin
        exp = '0;
        report("unexpected result", exp, got);
        return;
      end
      exp = pending_tokens.pop_front();
      if (got.text_valid !== exp.text_valid || got.text_byte !== exp.text_byte ||
          got.token_valid !== exp.token_valid || got.token_kind !== exp.token_kind ||
          got.error_code !== exp.error_code || got.last_of_run !== exp.last_of_run)
        report("field", exp, got);
    endfunction
  endclass

  lexer_scoreboard sb = new();

  int cycle_count   = 0;
  int items_sent    = 0;
  int hold_requests = 0;
  int holds_done    = 0;
  bit steady        = 1'b0;

  script_token_lexer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #CLK_HALF clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYC) begin
      $display("script_token_lexer verification failed");
      $finish;
    end
  end

  // handshake monitors
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_item);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_item);
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side backpressure
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else begin
        if (holds_done != hold_requests) begin
          holds_done++;
          stall_left = LONG_HOLD;
        end else if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
        if (stall_left > 0) begin
          out_ready <= 1'b0;
          stall_left--;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_item(stl_in_t it);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    stl_in_t it;
    it.data_byte     = b;
    it.end_of_source = 1'b0;
    send_item(it);
  endtask

  task automatic send_eos();
    stl_in_t it;
    it.data_byte     = 8'($urandom_range(0, 255));
    it.end_of_source = 1'b1;
    send_item(it);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // sender pause until the block has caught up
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_tokens.size() != 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return 8'("0" + r - 52);
  endfunction

  function automatic logic [7:0] rand_not(logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == avoid);
    return b;
  endfunction

  // one token with random content, or a lone bang, an ignored high byte or whitespace
  task automatic send_random_token();
    string w;
    string ops;
    logic [7:0] b;
    ops = "+-*/();";
    case ($urandom_range(0, 13))
      0: begin
        send_byte(8'("0" + $urandom_range(0, 9)));
        repeat ($urandom_range(0, 4))
          send_byte(($urandom_range(0, 3) == 0) ? 8'(".") : 8'("0" + $urandom_range(0, 9)));
      end
      1, 2: begin
        // keyword, or a near miss of one
        w = lexer_scoreboard::kw_word($urandom_range(0, 5));
        case ($urandom_range(0, 3))
          0: send_text(w.substr(0, w.len() - 2));
          1: begin send_text(w); send_byte(rand_alnum()); end
          default: send_text(w);
        endcase
      end
      3: begin
        b = rand_alnum();
        if (b <= "9") b = "x";
        send_byte(b);
        repeat ($urandom_range(0, 9)) send_byte(rand_alnum());
      end
      4: begin
        send_byte("\"");
        repeat ($urandom_range(0, 5)) send_byte(rand_not("\""));
        send_byte("\"");
      end
      5: begin
        send_byte("'");
        if ($urandom_range(0, 2) == 0) begin
          send_byte("\\");
          send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_byte(rand_not("\\"));
        end
        send_byte("'");
      end
      6, 7: send_byte(ops[$urandom_range(0, 6)]);
      8:  send_text("=");
      9:  send_text("==");
      10: send_text("!=");
      11: send_byte("!");
      12: send_byte(8'($urandom_range(128, 255)));
      default: send_byte(($urandom_range(0, 1) == 0) ? 8'(" ") : 8'($urandom_range(9, 13)));
    endcase
  endtask

  // one source text: tokens, sometimes a broken or noisy tail, then end of source
  task automatic send_random_source();
    int tail;
    repeat ($urandom_range(0, 10)) begin
      send_random_token();
      if ($urandom_range(0, 1) == 0) send_byte(" ");
    end
    tail = $urandom_range(0, 11);
    case (tail)
      0: repeat ($urandom_range(3, 10)) send_byte(8'($urandom_range(0, 255)));
      1: begin
        send_byte("\"");
        repeat ($urandom_range(0, 4)) send_byte(rand_not("\""));
      end
      2: begin
        send_byte("'");
        if ($urandom_range(0, 1) == 0) send_byte(rand_not("\\"));
      end
      3: begin
        // bad byte where the closing quote belongs, then ignored bytes
        send_byte("'");
        send_byte(rand_not("\\"));
        send_byte(rand_not("'"));
        repeat ($urandom_range(0, 4)) send_random_token();
      end
      default: ;
    endcase
    send_eos();
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: byte extremes, operators, escape, lone bang, both errors and the latch
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("ana==7.0!x!=");
    send_text("'\\''");
    send_eos();
    send_text("\"a");
    send_eos();
    send_byte("z");
    send_eos();
    send_text("'ab");
    send_eos();
    wait_drained();

    // random with a long receiver hold while items keep coming
    hold_requests++;
    while (items_sent < 300) send_random_source();
    wait_drained();

    // back to back, no idling on either side
    steady = 1'b1;
    while (items_sent < 450) send_random_source();
    steady = 1'b0;
    wait_drained();

    // random again with a second long hold
    hold_requests++;
    while (items_sent < 620) send_random_source();
    wait_drained();

    $display("covered %0d input items, %0d results checked, %0d tokens, %0d error reports",
             sb.bytes_noted, sb.results_checked, sb.tokens_seen, sb.errors_seen);
    $display("mismatches %0d, results still owed %0d", sb.mismatches, sb.pending_tokens.size());
    if (sb.mismatches == 0 && sb.pending_tokens.size() == 0) begin
      $display("script_token_lexer verification clean");
    end else begin
      $display("script_token_lexer verification failed");
    end
    $finish;
  end

endmodule
